// ----- hw/rtl/gpu_load_dvfs_governor_unit_assert.svh -----
// assertion macros shared by the governor modules
// each macro expects clk_i and rst_ni in the enclosing module
`ifndef GPU_LOAD_DVFS_GOVERNOR_UNIT_ASSERT_SVH
`define GPU_LOAD_DVFS_GOVERNOR_UNIT_ASSERT_SVH

// same-cycle implication
`define GLDG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gldg_pkg.sv -----
`default_nettype none

package gldg_pkg;

  // input transaction
  typedef struct packed {
    logic        operation;
    logic [31:0] sample_total_us;
    logic [31:0] sample_busy_us;
    logic [2:0]  current_level;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic       change_valid;
    logic [2:0] new_level;
    logic       evaluated;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_PERFORMANCE = 2'd0,
    MODE_POWERSAVE   = 2'd1,
    MODE_INTERACTIVE = 2'd2,
    MODE_LOAD_HIST   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_FLOOR       = 3'd1,
    CFG_UP_THRESH   = 3'd2,
    CFG_DOWN_THRESH = 3'd3,
    CFG_POLL_WINDOW = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef struct packed {
    mode_e       mode;
    logic [14:0] floor_us;
    logic [6:0]  up_load_threshold;
    logic [6:0]  down_load_threshold;
    logic [19:0] poll_window_us;
  } cfg_t;

  // arithmetic constants
  localparam int unsigned AccW      = 32;
  localparam int unsigned MulBW     = 13;
  localparam int unsigned ProdW     = AccW + MulBW;
  localparam int unsigned LoadShift = 19;
  localparam logic [MulBW-1:0] LoadScale = 13'd5243;
  localparam logic [MulBW-1:0] Percent   = 13'd100;
  localparam logic [2:0] TopStepLevel = 3'd3;
  localparam logic [2:0] TableLevels  = 3'd5;

  // load-history thresholds per level
  typedef struct packed {
    logic       down_ok;
    logic [6:0] down;
    logic       up_ok;
    logic [6:0] up;
  } hist_thr_t;

  function automatic hist_thr_t hist_thr(input logic [2:0] level);
    hist_thr_t t;
    t = '0;
    unique case (level)
      3'd0: begin
        t.down_ok = 1'b1;
        t.down    = 7'd65;
      end
      3'd1: begin
        t.down_ok = 1'b1;
        t.down    = 7'd50;
        t.up_ok   = 1'b1;
        t.up      = 7'd75;
      end
      3'd2: begin
        t.down_ok = 1'b1;
        t.down    = 7'd30;
        t.up_ok   = 1'b1;
        t.up      = 7'd55;
      end
      3'd3: begin
        t.up_ok = 1'b1;
        t.up    = 7'd40;
      end
      3'd4: begin
        t.up_ok = 1'b1;
        t.up    = 7'd0;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  // microcode word fields
  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {
    MA_BIN_BUSY = 2'd0,
    MA_WIN_BUSY = 2'd1,
    MA_WIN_WALL = 2'd2
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_LOAD_SCALE = 2'd0,
    MB_PERCENT    = 2'd1,
    MB_DOWN       = 2'd2,
    MB_UP_PLUS1   = 2'd3
  } mul_b_e;

  typedef enum logic [1:0] {
    DEC_NONE        = 2'd0,
    DEC_INTERACTIVE = 2'd1,
    DEC_HIST_DOWN   = 2'd2,
    DEC_HIST_UP     = 2'd3
  } dec_e;

  typedef enum logic [2:0] {
    JMP_NONE        = 3'd0,
    JMP_SLEEP       = 3'd1,
    JMP_GATE_FAIL   = 3'd2,
    JMP_INTERACTIVE = 3'd3,
    JMP_WIN_SHORT   = 3'd4
  } jmp_e;

  typedef struct packed {
    logic   add_bin;
    logic   add_win;
    logic   clr_bin;
    logic   clr_win;
    logic   ld_prod_a;
    logic   ld_prod_b;
    mul_a_e mul_a;
    mul_b_e mul_b;
    dec_e   dec;
    logic   set_eval;
    logic   done;
    jmp_e   jmp;
    step_t  target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic   start;
    logic   fire;
    ucode_t uw;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic is_sleep;
    logic gate_fail;
    logic is_interactive;
    logic win_short;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gldg_cfg_regs.sv -----
`default_nettype none

module gldg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [gldg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gldg_pkg::CfgDataW-1:0] cfg_wdata_i,
  output gldg_pkg::cfg_t                     cfg_o
);
  import gldg_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:        cfg_d.mode                = mode_e'(cfg_wdata_i[1:0]);
        CFG_FLOOR:       cfg_d.floor_us            = cfg_wdata_i[14:0];
        CFG_UP_THRESH:   cfg_d.up_load_threshold   = cfg_wdata_i[6:0];
        CFG_DOWN_THRESH: cfg_d.down_load_threshold = cfg_wdata_i[6:0];
        CFG_POLL_WINDOW: cfg_d.poll_window_us      = cfg_wdata_i[19:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode                <= MODE_INTERACTIVE;
      cfg_q.floor_us            <= 15'd5000;
      cfg_q.up_load_threshold   <= 7'd70;
      cfg_q.down_load_threshold <= 7'd45;
      cfg_q.poll_window_us      <= 20'd100000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/gldg_datapath.sv -----
`default_nettype none

module gldg_datapath #(
  parameter int unsigned NUM_LEVELS = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gldg_pkg::cfg_t      cfg_i,
  input  wire gldg_pkg::in_item_t  in_data_i,
  input  wire gldg_pkg::dp_ctrl_t  ctrl_i,
  output gldg_pkg::dp_status_t     status_o,
  output gldg_pkg::out_item_t      out_data_o
);
  import gldg_pkg::*;

  localparam logic [4:0] LevelLimit = 5'(NUM_LEVELS);

  in_item_t        item_q;
  logic [AccW-1:0] bin_total_q, bin_busy_q, win_wall_q, win_busy_q;
  logic [AccW-1:0] bin_total_d, bin_busy_d, win_wall_d, win_busy_d;
  logic [ProdW-1:0] prod_a_q, prod_b_q, product;
  logic [AccW-1:0]  mul_a;
  logic [MulBW-1:0] mul_b;
  logic [7:0]       up_plus1;
  logic             change_q, change_d;
  logic [3:0]       target_q, target_d;
  logic             change_final;
  logic             emit;
  out_item_t        result_q, result_d;
  hist_thr_t        thr;
  logic [ProdW-LoadShift-1:0] load;
  logic [2:0]       lvl;
  ucode_t           uw;

  assign uw   = ctrl_i.uw;
  assign emit = ctrl_i.fire && uw.done;
  assign lvl  = item_q.current_level;
  assign thr  = hist_thr(lvl);

  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
  endfunction

  // capture the transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      item_q <= in_data_i;
    end
  end

  // status for conditional jumps
  always_comb begin
    status_o.is_sleep       = item_q.operation;
    status_o.gate_fail      = (bin_total_q < AccW'(cfg_i.floor_us))
                              || (item_q.sample_total_us == '0)
                              || (cfg_i.mode == MODE_PERFORMANCE)
                              || (cfg_i.mode == MODE_POWERSAVE);
    status_o.is_interactive = (cfg_i.mode == MODE_INTERACTIVE);
    status_o.win_short      = !(win_wall_q > AccW'(cfg_i.poll_window_us));
  end

  // accumulator updates
  always_comb begin
    bin_total_d = bin_total_q;
    bin_busy_d  = bin_busy_q;
    win_wall_d  = win_wall_q;
    win_busy_d  = win_busy_q;
    if (ctrl_i.fire) begin
      if (uw.clr_bin) begin
        bin_total_d = '0;
        bin_busy_d  = '0;
      end else if (uw.add_bin) begin
        bin_total_d = sat_add(bin_total_q, item_q.sample_total_us);
        bin_busy_d  = sat_add(bin_busy_q, item_q.sample_busy_us);
      end
      if (uw.clr_win) begin
        win_wall_d = '0;
        win_busy_d = '0;
      end else if (uw.add_win) begin
        win_wall_d = sat_add(win_wall_q, item_q.sample_total_us);
        win_busy_d = sat_add(win_busy_q, item_q.sample_busy_us);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_total_q <= '0;
      bin_busy_q  <= '0;
      win_wall_q  <= '0;
      win_busy_q  <= '0;
    end else begin
      bin_total_q <= bin_total_d;
      bin_busy_q  <= bin_busy_d;
      win_wall_q  <= win_wall_d;
      win_busy_q  <= win_busy_d;
    end
  end

  // shared multiplier operands
  assign up_plus1 = {1'b0, thr.up} + 8'd1;

  always_comb begin
    unique case (uw.mul_a)
      MA_BIN_BUSY: mul_a = bin_busy_q;
      MA_WIN_BUSY: mul_a = win_busy_q;
      MA_WIN_WALL: mul_a = win_wall_q;
      default:     mul_a = '0;
    endcase
    unique case (uw.mul_b)
      MB_LOAD_SCALE: mul_b = LoadScale;
      MB_PERCENT:    mul_b = Percent;
      MB_DOWN:       mul_b = MulBW'(thr.down);
      MB_UP_PLUS1:   mul_b = MulBW'(up_plus1);
      default:       mul_b = '0;
    endcase
  end

  assign product = ProdW'(mul_a) * ProdW'(mul_b);

  // product registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && uw.ld_prod_a) begin
      prod_a_q <= product;
    end
    if (ctrl_i.fire && uw.ld_prod_b) begin
      prod_b_q <= product;
    end
  end

  assign load = prod_a_q[ProdW-1:LoadShift];

  // level decisions; load < t is 100*busy < t*wall, load > t is 100*busy >= (t+1)*wall
  always_comb begin
    change_d = change_q;
    target_d = target_q;
    if (ctrl_i.start) begin
      change_d = 1'b0;
      target_d = '0;
    end else if (ctrl_i.fire) begin
      unique case (uw.dec)
        DEC_INTERACTIVE: begin
          if (lvl != 3'd0 && lvl <= TopStepLevel) begin
            if (load >= (ProdW-LoadShift)'(cfg_i.up_load_threshold)) begin
              change_d = 1'b1;
              target_d = {1'b0, lvl} - 4'd1;
            end
          end else if (lvl == 3'd0) begin
            if (load < (ProdW-LoadShift)'(cfg_i.down_load_threshold)) begin
              change_d = 1'b1;
              target_d = 4'd1;
            end
          end
        end
        DEC_HIST_DOWN: begin
          if (lvl < TableLevels && thr.down_ok && prod_a_q < prod_b_q) begin
            change_d = 1'b1;
            target_d = {1'b0, lvl} + 4'd1;
          end
        end
        DEC_HIST_UP: begin
          if (!change_q && lvl < TableLevels && thr.up_ok && prod_a_q >= prod_b_q) begin
            change_d = 1'b1;
            target_d = {1'b0, lvl} - 4'd1;
          end
        end
        default: begin
          change_d = change_q;
          target_d = target_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_q <= 1'b0;
      target_q <= '0;
    end else begin
      change_q <= change_d;
      target_q <= target_d;
    end
  end

  // drop steps that leave the level range
  assign change_final = change_d && ({2'b00, lvl} < LevelLimit)
                        && ({1'b0, target_d} < LevelLimit);

  always_comb begin
    result_d.change_valid = change_final;
    result_d.new_level    = change_final ? target_d[2:0] : 3'd0;
    result_d.evaluated    = uw.set_eval;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_data_o = result_q;

  `include "gpu_load_dvfs_governor_unit_assert.svh"

  `GLDG_ASSERT_NEXT(a_clear_bins, ctrl_i.fire && uw.clr_bin,
                    bin_total_q == '0 && bin_busy_q == '0, "bins not cleared")
  `GLDG_ASSERT_SAME(a_eval_mode, emit && uw.set_eval,
                    cfg_i.mode == MODE_INTERACTIVE || cfg_i.mode == MODE_LOAD_HIST,
                    "evaluation outside an evaluating mode")
  `GLDG_ASSERT_SAME(a_change_needs_eval, emit && change_final, uw.set_eval,
                    "level change without evaluation")

endmodule

`default_nettype wire

// ----- hw/rtl/gldg_sequencer.sv -----
`default_nettype none

module gldg_sequencer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire gldg_pkg::dp_status_t status_i,
  output gldg_pkg::dp_ctrl_t        ctrl_o
);
  import gldg_pkg::*;

  // program entry points
  localparam step_t StFirst     = 4'd0;
  localparam step_t StHistNoWin = 4'd10;
  localparam step_t StInter     = 4'd11;
  localparam step_t StNoEval    = 4'd13;
  localparam step_t StSleep     = 4'd14;
  localparam step_t StLast      = 4'd14;

  // microprogram
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    unique case (step)
      4'd0: begin
        w.jmp    = JMP_SLEEP;
        w.target = StSleep;
      end
      4'd1: w.add_bin = 1'b1;
      4'd2: begin
        w.jmp    = JMP_GATE_FAIL;
        w.target = StNoEval;
      end
      4'd3: begin
        w.jmp    = JMP_INTERACTIVE;
        w.target = StInter;
      end
      4'd4: w.add_win = 1'b1;
      4'd5: begin
        w.jmp    = JMP_WIN_SHORT;
        w.target = StHistNoWin;
      end
      4'd6: begin
        w.mul_a     = MA_WIN_BUSY;
        w.mul_b     = MB_PERCENT;
        w.ld_prod_a = 1'b1;
      end
      4'd7: begin
        w.mul_a     = MA_WIN_WALL;
        w.mul_b     = MB_DOWN;
        w.ld_prod_b = 1'b1;
      end
      4'd8: begin
        w.dec       = DEC_HIST_DOWN;
        w.mul_a     = MA_WIN_WALL;
        w.mul_b     = MB_UP_PLUS1;
        w.ld_prod_b = 1'b1;
      end
      4'd9: begin
        w.dec      = DEC_HIST_UP;
        w.clr_bin  = 1'b1;
        w.clr_win  = 1'b1;
        w.set_eval = 1'b1;
        w.done     = 1'b1;
      end
      4'd10: begin
        w.clr_bin  = 1'b1;
        w.set_eval = 1'b1;
        w.done     = 1'b1;
      end
      4'd11: begin
        w.mul_a     = MA_BIN_BUSY;
        w.mul_b     = MB_LOAD_SCALE;
        w.ld_prod_a = 1'b1;
      end
      4'd12: begin
        w.dec      = DEC_INTERACTIVE;
        w.clr_bin  = 1'b1;
        w.set_eval = 1'b1;
        w.done     = 1'b1;
      end
      4'd13: w.done = 1'b1;
      4'd14: begin
        w.clr_bin = 1'b1;
        w.clr_win = 1'b1;
        w.done    = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  logic   running_q, running_d;
  logic   out_valid_q, out_valid_d;
  step_t  step_q, step_d;
  ucode_t uw;
  logic   start, hold, fire, taken;

  assign uw         = ucode_rom(step_q);
  assign in_stall_o = running_q;
  assign start      = in_valid_i && !running_q;
  // the final step waits for a free output slot
  assign hold       = uw.done && out_valid_q && out_stall_i;
  assign fire       = running_q && !hold;

  // jump condition
  always_comb begin
    unique case (uw.jmp)
      JMP_NONE:        taken = 1'b0;
      JMP_SLEEP:       taken = status_i.is_sleep;
      JMP_GATE_FAIL:   taken = status_i.gate_fail;
      JMP_INTERACTIVE: taken = status_i.is_interactive;
      JMP_WIN_SHORT:   taken = status_i.win_short;
      default:         taken = 1'b0;
    endcase
  end

  // step counter and run flag
  always_comb begin
    running_d = running_q;
    step_d    = step_q;
    if (start) begin
      running_d = 1'b1;
      step_d    = StFirst;
    end else if (fire) begin
      if (uw.done) begin
        running_d = 1'b0;
        step_d    = StFirst;
      end else if (taken) begin
        step_d = uw.target;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  // result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && uw.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      step_q      <= StFirst;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ctrl_o.start = start;
  assign ctrl_o.fire  = fire;
  assign ctrl_o.uw    = uw;

  `include "gpu_load_dvfs_governor_unit_assert.svh"

  `GLDG_ASSERT_NEXT(a_start_runs, start, running_q && step_q == StFirst,
                    "accepted transaction did not start the program")
  `GLDG_ASSERT_SAME(a_step_range, running_q, step_q <= StLast,
                    "step counter outside the program")
  `GLDG_ASSERT_NEXT(a_done_result, fire && uw.done, out_valid_q && !running_q,
                    "finished program left no result")

endmodule

`default_nettype wire

// ----- hw/rtl/gpu_load_dvfs_governor_unit.sv -----
`default_nettype none

// Load-threshold power-level governor. Each accepted transaction is one idle sample or a
// sleep command; every transaction returns exactly one result. A small microprogram runs
// one step per clock (the final step waits while a stalled result holds the output) over
// a shared 32x13 multiplier and the saturating accumulators. Paths: sleep, floor not
// reached or a fixed mode, interactive, load-history with the window open or closing
// (three multiplies, two compares), then the output register. The next transaction is
// taken the cycle after the final step, while the previous result may still wait there.
// Configuration writes are always ready; issue them only while the block is idle.
module gpu_load_dvfs_governor_unit #(
  parameter int unsigned NUM_LEVELS = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire gldg_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output gldg_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gldg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gldg_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gldg_pkg::*;

  cfg_t       cfg;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  gldg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // program sequencer
  gldg_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // accumulators, multiplier and decisions
  gldg_datapath #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
